// File: sv/tme_pkg.sv
// Shared types, codes and constants for the TWI message engine.
`default_nettype none
package tme_pkg;

	localparam int unsigned MsgBytes = 4;
	localparam int unsigned IdxW     = 3;
	localparam int unsigned AddrW    = 3;

	typedef enum logic [1:0] {
		OP_EVENT   = 2'd0,
		OP_START   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_ARM     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		M_READY     = 3'd0,
		M_WRITING   = 3'd1,
		M_READING   = 3'd2,
		M_RECEIVED  = 3'd3,
		M_SEND_OK   = 3'd4,
		M_SEND_FAIL = 3'd5
	} mode_t;

	localparam logic [2:0] RES_NONE      = 3'd0;
	localparam logic [2:0] RES_ACCEPTED  = 3'd1;
	localparam logic [2:0] RES_BUSY      = 3'd2;
	localparam logic [2:0] RES_SENT      = 3'd3;
	localparam logic [2:0] RES_SEND_FAIL = 3'd4;
	localparam logic [2:0] RES_RECEIVED  = 3'd5;
	localparam logic [2:0] RES_UNKNOWN   = 3'd6;

	// bus controller status codes
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_SLA_ACK    = 8'h18;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_SLA_NACK   = 8'h20;
	localparam logic [7:0] ST_DATA_NACK  = 8'h30;
	localparam logic [7:0] ST_ARB_LOST   = 8'h38;
	localparam logic [7:0] ST_OWN_ADDR   = 8'h60;
	localparam logic [7:0] ST_GEN_CALL   = 8'h70;
	localparam logic [7:0] ST_RX_DATA    = 8'h80;
	localparam logic [7:0] ST_RX_DATA_NA = 8'h88;
	localparam logic [7:0] ST_RX_GC      = 8'h90;
	localparam logic [7:0] ST_RX_GC_NA   = 8'h98;
	localparam logic [7:0] ST_RX_STOP    = 8'hA0;
	localparam logic [7:0] ST_BUS_ERROR  = 8'h00;

	localparam logic [AddrW-1:0] REG_SERVER_ID = 3'd0;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] status_code;
		logic [7:0] rx_byte;
		logic [6:0] dest_id;
		logic [7:0] data_byte0;
		logic [7:0] data_byte1;
		logic [7:0] data_byte2;
		logic [7:0] data_byte3;
	} in_item_t;

	typedef struct packed {
		logic        ctrl_write;
		logic        ctrl_clear_flag;
		logic        ctrl_start;
		logic        ctrl_stop;
		logic        ctrl_ack;
		logic        ctrl_enable;
		logic        ctrl_irq_enable;
		logic [7:0]  tx_data;
		logic        tx_data_valid;
		logic [2:0]  engine_state;
		logic [31:0] rx_message;
		logic [2:0]  result_code;
	} out_item_t;

endpackage
`default_nettype wire

// File: sv/tme_cfg.sv
// APB-style register port holding the node identity.
`default_nettype none
module tme_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [tme_pkg::AddrW-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready
);

	logic [6:0] server_id_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_id_q <= 7'd0;
		end else if (wr_en && paddr[2] == tme_pkg::REG_SERVER_ID[2]) begin
			server_id_q <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == tme_pkg::REG_SERVER_ID[2]) begin
			prdata = {25'd0, server_id_q};
		end
	end

endmodule
`default_nettype wire

// File: sv/tme_core.sv
// Engine state and the single-pass decode of one item into a result.
`default_nettype none
module tme_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire tme_pkg::in_item_t  item,
	output tme_pkg::out_item_t      result
);

	localparam logic [tme_pkg::IdxW-1:0] Full = tme_pkg::IdxW'(tme_pkg::MsgBytes);

	tme_pkg::mode_t             mode_q, mode_d;
	logic [7:0]                 send_buf_q [tme_pkg::MsgBytes];
	logic [tme_pkg::IdxW-1:0]   send_idx_q, send_idx_d;
	logic [7:0]                 dest_addr_q, dest_addr_d;
	logic [7:0]                 recv_buf_q [tme_pkg::MsgBytes];
	logic [7:0]                 recv_buf_d [tme_pkg::MsgBytes];
	logic [tme_pkg::IdxW-1:0]   recv_idx_q, recv_idx_d;
	logic                       load_send;
	logic                       wr, clr, sta, sto, ack, en, ie, txv;
	logic [7:0]                 tx;
	logic [2:0]                 res;

	always_comb begin
		mode_d      = mode_q;
		send_idx_d  = send_idx_q;
		dest_addr_d = dest_addr_q;
		recv_buf_d  = recv_buf_q;
		recv_idx_d  = recv_idx_q;
		load_send   = 1'b0;
		wr  = 1'b1;
		clr = 1'b0;
		sta = 1'b0;
		sto = 1'b0;
		ack = 1'b0;
		en  = 1'b0;
		ie  = 1'b0;
		txv = 1'b0;
		tx  = 8'd0;
		res = tme_pkg::RES_NONE;
		unique case (tme_pkg::op_t'(item.operation))
			tme_pkg::OP_START: begin
				if (mode_q != tme_pkg::M_READY) begin
					wr  = 1'b0;
					res = tme_pkg::RES_BUSY;
				end else begin
					mode_d      = tme_pkg::M_WRITING;
					load_send   = 1'b1;
					send_idx_d  = '0;
					dest_addr_d = {item.dest_id + 7'd1, 1'b0};
					clr = 1'b1;
					sta = 1'b1;
					en  = 1'b1;
					ie  = 1'b1;
					res = tme_pkg::RES_ACCEPTED;
				end
			end
			tme_pkg::OP_RELEASE: begin
				ack = 1'b1;
				en  = 1'b1;
				ie  = 1'b1;
				mode_d = tme_pkg::M_READY;
				unique case (mode_q)
					tme_pkg::M_SEND_OK:   res = tme_pkg::RES_SENT;
					tme_pkg::M_SEND_FAIL: res = tme_pkg::RES_SEND_FAIL;
					tme_pkg::M_RECEIVED:  res = tme_pkg::RES_RECEIVED;
					default: begin
						wr     = 1'b0;
						mode_d = mode_q;
					end
				endcase
			end
			tme_pkg::OP_ARM: begin
				mode_d = tme_pkg::M_READY;
				ack = 1'b1;
				en  = 1'b1;
				ie  = 1'b1;
			end
			default: begin
				clr = 1'b1;
				unique case (item.status_code) inside
					tme_pkg::ST_START: begin
						en  = 1'b1;
						ie  = 1'b1;
						txv = 1'b1;
						tx  = dest_addr_q;
					end
					tme_pkg::ST_SLA_ACK, tme_pkg::ST_DATA_ACK: begin
						en = 1'b1;
						ie = 1'b1;
						if (send_idx_q < Full) begin
							txv        = 1'b1;
							tx         = send_buf_q[send_idx_q[1:0]];
							send_idx_d = send_idx_q + 1'b1;
						end else begin
							mode_d = tme_pkg::M_SEND_OK;
							sto    = 1'b1;
						end
					end
					tme_pkg::ST_SLA_NACK, tme_pkg::ST_DATA_NACK, tme_pkg::ST_BUS_ERROR: begin
						mode_d = tme_pkg::M_SEND_FAIL;
						sto = 1'b1;
						en  = 1'b1;
						ie  = 1'b1;
					end
					tme_pkg::ST_ARB_LOST: begin
						mode_d = tme_pkg::M_SEND_FAIL;
						en = 1'b1;
						ie = 1'b1;
					end
					tme_pkg::ST_OWN_ADDR, tme_pkg::ST_GEN_CALL: begin
						mode_d     = tme_pkg::M_READING;
						recv_idx_d = '0;
						ack = 1'b1;
						en  = 1'b1;
						ie  = 1'b1;
					end
					tme_pkg::ST_RX_DATA, tme_pkg::ST_RX_GC: begin
						en = 1'b1;
						ie = 1'b1;
						// index saturates at a full message, extra bytes dropped
						if (recv_idx_q < Full) begin
							recv_buf_d[recv_idx_q[1:0]] = item.rx_byte;
							recv_idx_d = recv_idx_q + 1'b1;
						end
						ack = (recv_idx_d < Full);
					end
					tme_pkg::ST_RX_DATA_NA, tme_pkg::ST_RX_GC_NA, tme_pkg::ST_RX_STOP: begin
						mode_d = tme_pkg::M_RECEIVED;
					end
					default: begin
						res = tme_pkg::RES_UNKNOWN;
					end
				endcase
			end
		endcase
	end

	always_comb begin
		result.ctrl_write      = wr;
		result.ctrl_clear_flag = wr & clr;
		result.ctrl_start      = wr & sta;
		result.ctrl_stop       = wr & sto;
		result.ctrl_ack        = wr & ack;
		result.ctrl_enable     = wr & en;
		result.ctrl_irq_enable = wr & ie;
		result.tx_data         = tx;
		result.tx_data_valid   = txv;
		result.engine_state    = mode_d;
		result.rx_message      = {recv_buf_d[0], recv_buf_d[1], recv_buf_d[2], recv_buf_d[3]};
		result.result_code     = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= tme_pkg::M_READY;
			send_idx_q  <= '0;
			dest_addr_q <= 8'd0;
			recv_idx_q  <= '0;
			for (int i = 0; i < tme_pkg::MsgBytes; i++) begin
				recv_buf_q[i] <= 8'd0;
			end
		end else if (accept) begin
			mode_q      <= mode_d;
			send_idx_q  <= send_idx_d;
			dest_addr_q <= dest_addr_d;
			recv_idx_q  <= recv_idx_d;
			recv_buf_q  <= recv_buf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && load_send) begin
			send_buf_q[0] <= item.data_byte0;
			send_buf_q[1] <= item.data_byte1;
			send_buf_q[2] <= item.data_byte2;
			send_buf_q[3] <= item.data_byte3;
		end
	end

endmodule
`default_nettype wire

// File: sv/tme_out_stage.sv
// Result register with a skid entry so one further input is taken under output stall.
`default_nettype none
module tme_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tme_pkg::out_item_t push_data,
	output logic                    full,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tme_pkg::out_item_t      out_data
);

	tme_pkg::out_item_t main_q, skid_q;
	logic               main_valid_q, skid_valid_q;
	logic               pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end else if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

endmodule
`default_nettype wire

// File: sv/twi_message_engine.sv
// Top level of the TWI message engine.
//
// Input channel (in_valid/in_stall/in_data) carries one item per transaction:
// a bus status event, a start write, a release or an arm of slave receive.
// Every accepted item yields exactly one result transaction on the output
// channel (out_valid/out_stall/out_data): control word, transmit byte,
// engine state after the item, the received message and a result code.
// The item is decoded against the engine state in the accepting cycle and the
// result is registered in the output register, or in the skid entry while it
// stalls. Throughput is one item per clock while in_stall is low.
// When the receiver stalls, one further result is held in a skid entry and
// in_stall rises; it drops once the output register drains.
// Reset (arst_n low) returns the engine to ready with empty indices and a
// cleared receive buffer, drops any pending result and issues no control word.
// The APB port holds server_id at addresses 0 to 3 (only paddr[2] is decoded);
// it is read back only and does not change any result.
`default_nettype none
module twi_message_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire tme_pkg::in_item_t         in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output tme_pkg::out_item_t             out_data,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [tme_pkg::AddrW-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready
);

	logic               accept;
	logic               full;
	tme_pkg::out_item_t result;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	tme_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tme_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_data),
		.result (result)
	);

	tme_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// File: sv/tme_checker.sv
// Port-level checks for the TWI message engine, bound to the top level.
`default_nettype none
module tme_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire tme_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_no_word_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ctrl_write |->
			!out_data.ctrl_clear_flag && !out_data.ctrl_start && !out_data.ctrl_stop &&
			!out_data.ctrl_ack && !out_data.ctrl_enable && !out_data.ctrl_irq_enable)
		else $error("control bits set without a control word");

	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.tx_data_valid |-> out_data.tx_data == 8'd0)
		else $error("tx_data nonzero without tx_data_valid");

	a_release_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.result_code == tme_pkg::RES_SENT ||
			out_data.result_code == tme_pkg::RES_SEND_FAIL ||
			out_data.result_code == tme_pkg::RES_RECEIVED) |->
			out_data.ctrl_write && out_data.engine_state == tme_pkg::M_READY)
		else $error("finished transfer not returned to ready");

	a_start_writing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_code == tme_pkg::RES_ACCEPTED |->
			out_data.ctrl_start && out_data.engine_state == tme_pkg::M_WRITING)
		else $error("accepted write without start");

endmodule

bind twi_message_engine tme_checker u_tme_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
